[src/rtc_cal_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTC calendar package
// Word types, field limits and the month length table for the calendar.
// ----------------------------------------------------------------------------
package rtc_cal_pkg;

  // Action codes carried in the input word
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  // Time of day limits
  localparam logic [5:0] SEC_PER_MIN  = 6'd60;
  localparam logic [5:0] MIN_PER_HOUR = 6'd60;
  localparam logic [5:0] SEC_LAST     = 6'd59;
  localparam logic [5:0] MIN_LAST     = 6'd59;
  localparam logic [5:0] HOUR_LAST    = 6'd23;
  localparam logic [5:0] HOURS_PER_DAY = 6'd24;

  // Calendar limits
  localparam logic [2:0] WDAY_FIRST  = 3'd1;
  localparam logic [2:0] WDAY_LAST   = 3'd7;
  localparam logic [4:0] DATE_FIRST  = 5'd1;
  localparam logic [3:0] MONTH_FIRST = 4'd1;
  localparam logic [3:0] MONTH_LAST  = 4'd12;

  // Month codes with a length other than 31
  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_APR = 4'd4;
  localparam logic [3:0] MON_JUN = 4'd6;
  localparam logic [3:0] MON_SEP = 4'd9;
  localparam logic [3:0] MON_NOV = 4'd11;

  typedef struct packed {
    logic       action;
    logic [7:0] load_year;
    logic [3:0] load_month;
    logic [4:0] load_date;
    logic [2:0] load_weekday;
    logic [4:0] load_hour;
    logic [5:0] load_minute;
    logic [5:0] load_second;
  } in_word_t;

  typedef struct packed {
    logic [7:0] cur_year;
    logic [3:0] cur_month;
    logic [4:0] cur_date;
    logic [2:0] cur_weekday;
    logic [4:0] cur_hour;
    logic [5:0] cur_minute;
    logic [5:0] cur_second;
  } out_word_t;

  // Days in a month; any month code outside 1..12 counts as a long month.
  function automatic logic [4:0] month_len(input logic [3:0] month,
                                           input logic [7:0] year);
    logic [4:0] len;
    case (month)
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
      MON_FEB: len = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

[src/rtc_cal_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTC calendar input stage
// Registers one input word and holds it until the update stage takes it.
// ----------------------------------------------------------------------------
module rtc_cal_in_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  rtc_cal_pkg::in_word_t in_word_i,
  output logic                  vld_o,
  output rtc_cal_pkg::in_word_t word_o,
  input  logic                  take_i
);
  import rtc_cal_pkg::*;

  logic     vld_q, vld_d;
  in_word_t word_q;
  logic     accept;

  // Stall only while a held word is not being taken this cycle
  assign in_stall_o = vld_q & ~take_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign vld_d      = accept | (vld_q & ~take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= in_word_i;
    end
  end

  assign vld_o  = vld_q;
  assign word_o = word_q;

endmodule

[src/rtc_cal_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTC calendar core
// Applies a tick or a load to the time and calendar registers, which also
// serve as the result register.
// ----------------------------------------------------------------------------
module rtc_cal_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   vld_i,
  input  rtc_cal_pkg::in_word_t  word_i,
  output logic                   take_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output rtc_cal_pkg::out_word_t out_word_o
);
  import rtc_cal_pkg::*;

  logic       out_vld_q, out_vld_d;
  logic [5:0] sec_q, sec_d;
  logic [5:0] min_q, min_d;
  logic [5:0] hour_q, hour_d;
  logic [7:0] year_q, year_d;
  logic [3:0] month_q, month_d;
  logic [4:0] date_q, date_d;
  logic [2:0] wday_q, wday_d;

  logic       day_end;
  logic [5:0] date_inc;
  logic       s_wrap, m_wrap;
  logic [5:0] s_norm, m_norm, h_norm;
  logic [6:0] m_sum;

  assign take_o    = vld_i & (~out_vld_q | ~out_stall_i);
  assign out_vld_d = take_o | (out_vld_q & out_stall_i);

  // Normalize a loaded time so that minute and second stay below 60
  assign s_wrap = word_i.load_second >= SEC_PER_MIN;
  assign s_norm = s_wrap ? word_i.load_second - SEC_PER_MIN : word_i.load_second;
  assign m_sum  = {1'b0, word_i.load_minute} + {6'd0, s_wrap};
  assign m_wrap = m_sum >= {1'b0, MIN_PER_HOUR};
  assign m_norm = m_wrap ? 6'(m_sum - {1'b0, MIN_PER_HOUR}) : m_sum[5:0];
  assign h_norm = {1'b0, word_i.load_hour} + {5'd0, m_wrap};

  // Last second of the day, or a loaded hour past the end of the day
  assign day_end  = (hour_q >= HOURS_PER_DAY) |
                    ((hour_q == HOUR_LAST) & (min_q == MIN_LAST) & (sec_q == SEC_LAST));
  assign date_inc = {1'b0, date_q} + 6'd1;

  always_comb begin
    sec_d   = sec_q;
    min_d   = min_q;
    hour_d  = hour_q;
    year_d  = year_q;
    month_d = month_q;
    date_d  = date_q;
    wday_d  = wday_q;
    if (take_o) begin
      if (word_i.action == ACT_LOAD) begin
        sec_d   = s_norm;
        min_d   = m_norm;
        hour_d  = h_norm;
        year_d  = word_i.load_year;
        month_d = word_i.load_month;
        date_d  = word_i.load_date;
        wday_d  = word_i.load_weekday;
      end else if (day_end) begin
        sec_d  = 6'd0;
        min_d  = 6'd0;
        hour_d = 6'd0;
        wday_d = (wday_q == WDAY_LAST) ? WDAY_FIRST : wday_q + 3'd1;
        if (date_inc > {1'b0, month_len(month_q, year_q)}) begin
          date_d = DATE_FIRST;
          if (month_q >= MONTH_LAST) begin
            month_d = MONTH_FIRST;
            year_d  = year_q + 8'd1;
          end else begin
            month_d = month_q + 4'd1;
          end
        end else begin
          date_d = date_inc[4:0];
        end
      end else if (sec_q == SEC_LAST) begin
        sec_d = 6'd0;
        if (min_q == MIN_LAST) begin
          min_d  = 6'd0;
          hour_d = hour_q + 6'd1;
        end else begin
          min_d = min_q + 6'd1;
        end
      end else begin
        sec_d = sec_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      sec_q     <= 6'd0;
      min_q     <= 6'd0;
      hour_q    <= 6'd0;
      year_q    <= 8'd0;
      month_q   <= MONTH_FIRST;
      date_q    <= DATE_FIRST;
      wday_q    <= WDAY_FIRST;
    end else begin
      out_vld_q <= out_vld_d;
      sec_q     <= sec_d;
      min_q     <= min_d;
      hour_q    <= hour_d;
      year_q    <= year_d;
      month_q   <= month_d;
      date_q    <= date_d;
      wday_q    <= wday_d;
    end
  end

  assign out_valid_o            = out_vld_q;
  assign out_word_o.cur_year    = year_q;
  assign out_word_o.cur_month   = month_q;
  assign out_word_o.cur_date    = date_q;
  assign out_word_o.cur_weekday = wday_q;
  assign out_word_o.cur_hour    = hour_q[4:0];
  assign out_word_o.cur_minute  = min_q;
  assign out_word_o.cur_second  = sec_q;

endmodule

[src/rtc_calendar_counter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTC calendar counter, top level
// Calendar clock driven by one-second tick words or full date/time loads.
// ----------------------------------------------------------------------------
// Each input word is a one-second tick or a load of year, month, date,
// weekday and time; every word yields one result word with the updated
// date and time. A word is registered at the input and applied to the
// calendar registers once the core takes it; the calendar registers are
// themselves the result register, so when nothing stalls a word is accepted
// every cycle, and each result word passes through the input register and
// the calendar registers before it is presented. The time is
// kept as hour, minute and second counters; a loaded minute or second of 60
// or more carries into the next field, and a loaded hour past 23 rolls the
// day on the next tick. At day end the weekday wraps 7 to 1, the date wraps
// at the month length (29 days in February when the year is a multiple of
// four), the month wraps to 1 from 12 or any code above 12, and only then
// the year advances, 255 to 0. Out-of-range month codes count as 31-day
// months. Reset gives year 0, January 1st, weekday 1, 00:00:00.
// ----------------------------------------------------------------------------
module rtc_calendar_counter (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  rtc_cal_pkg::in_word_t  in_word_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output rtc_cal_pkg::out_word_t out_word_o
);
  import rtc_cal_pkg::*;

  logic     stage_vld;
  in_word_t stage_word;
  logic     stage_take;

  // Hold the incoming word until the core can apply it
  rtc_cal_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .vld_o      (stage_vld),
    .word_o     (stage_word),
    .take_i     (stage_take)
  );

  // Advance the calendar and present the result word
  rtc_cal_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vld_i       (stage_vld),
    .word_i      (stage_word),
    .take_o      (stage_take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

[src/rtc_cal_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTC calendar port checker
// Port-level checks on the calendar counter, bound to the top level.
// ----------------------------------------------------------------------------
module rtc_cal_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input rtc_cal_pkg::out_word_t out_word_o
);
  import rtc_cal_pkg::*;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_word_o)))
    else $error("result word changed while stalled");

  // Input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled with the output free");

  // Minute and second are always normalized
  a_time_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_word_o.cur_second < SEC_PER_MIN) &&
                     (out_word_o.cur_minute < MIN_PER_HOUR)))
    else $error("minute or second out of range");

  // An empty output fills only from a word that the input stage accepted
  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result word appeared without input");

endmodule

bind rtc_calendar_counter rtc_cal_checker u_rtc_cal_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTC calendar counter testbench
// Drives tick and load words through the valid/stall handshake with random
// gaps on both sides. Each result is compared field by field against the
// oldest prediction, from a local calendar model or a typed directed row.
// ----------------------------------------------------------------------------
module tb;
  import rtc_cal_pkg::*;

  localparam int unsigned SECS_PER_DAY = 86400;
  localparam int          RAND_WORDS   = 1100;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          REPORT_MAX   = 10;

  // Directed stimulus row: the word to send and, where it is obvious, the
  // result typed in by hand. Other rows take the local calendar's answer.
  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t want;
  } step_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_word_o;

  // Local copy of the calendar state
  int unsigned cal_secs  = 0;
  logic [7:0]  cal_year  = 8'd0;
  int unsigned cal_month = 1;
  int unsigned cal_date  = 1;
  int unsigned cal_wday  = 1;

  // Run statistics
  int day_rolls    = 0;
  int month_rolls  = 0;
  int year_rolls   = 0;
  int loads_seen   = 0;
  int words_sent   = 0;
  int results_seen = 0;
  int mismatches   = 0;
  int cycle_count  = 0;

  out_word_t due_cal_q[$];   // predicted result words, oldest first
  step_row_t plan[$];

  rtc_calendar_counter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watchdog: end a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               due_cal_q.size());
      $display("FAIL rtc_calendar_counter");
      $finish;
    end
  end

  // Days in a month; codes outside 1..12 count as long months
  function automatic int unsigned days_in(int unsigned mo, logic [7:0] yr);
    int unsigned len;
    case (mo)
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 30;
      MON_FEB: len = (yr % 4 == 0) ? 29 : 28;
      default: len = 31;
    endcase
    return len;
  endfunction

  // Apply one word to the local calendar and return the result it yields
  function automatic out_word_t advance_calendar(in_word_t w);
    out_word_t r;
    if (w.action == ACT_LOAD) begin
      loads_seen++;
      cal_year  = w.load_year;
      cal_month = w.load_month;
      cal_date  = w.load_date;
      cal_wday  = w.load_weekday;
      cal_secs  = int'(w.load_hour) * 3600 + int'(w.load_minute) * 60
                  + int'(w.load_second);
    end else begin
      cal_secs++;
      if (cal_secs >= SECS_PER_DAY) begin
        // Day ends: wrap the clock and step the calendar
        cal_secs = 0;
        day_rolls++;
        cal_wday++;
        if (cal_wday > 7) cal_wday = 1;
        cal_date++;
        if (cal_date > days_in(cal_month, cal_year)) begin
          cal_date = 1;
          cal_month++;
          month_rolls++;
          if (cal_month > 12) begin
            cal_month = 1;
            cal_year++;
            year_rolls++;
          end
        end
      end
    end
    r.cur_year    = cal_year;
    r.cur_month   = 4'(cal_month);
    r.cur_date    = 5'(cal_date);
    r.cur_weekday = 3'(cal_wday);
    r.cur_hour    = 5'(cal_secs / 3600);
    r.cur_minute  = 6'((cal_secs % 3600) / 60);
    r.cur_second  = 6'(cal_secs % 60);
    return r;
  endfunction

  function automatic in_word_t load_word(int y, int mo, int d, int wd,
                                         int h, int mi, int s);
    in_word_t w;
    w.action       = ACT_LOAD;
    w.load_year    = 8'(y);
    w.load_month   = 4'(mo);
    w.load_date    = 5'(d);
    w.load_weekday = 3'(wd);
    w.load_hour    = 5'(h);
    w.load_minute  = 6'(mi);
    w.load_second  = 6'(s);
    return w;
  endfunction

  function automatic out_word_t cal_out(int y, int mo, int d, int wd,
                                        int h, int mi, int s);
    out_word_t r;
    r.cur_year    = 8'(y);
    r.cur_month   = 4'(mo);
    r.cur_date    = 5'(d);
    r.cur_weekday = 3'(wd);
    r.cur_hour    = 5'(h);
    r.cur_minute  = 6'(mi);
    r.cur_second  = 6'(s);
    return r;
  endfunction

  // Word with every field random; only the action is forced
  function automatic in_word_t random_word(logic act);
    logic [63:0] raw;
    in_word_t    w;
    raw      = {$urandom(), $urandom()};
    w        = in_word_t'(raw[$bits(in_word_t)-1:0]);
    w.action = act;
    return w;
  endfunction

  function automatic void add_row(in_word_t w, bit typed, out_word_t want);
    step_row_t row;
    row.word  = w;
    row.typed = typed;
    row.want  = want;
    plan.push_back(row);
  endfunction

  function automatic string fmt_cal(out_word_t c);
    return $sformatf("y%0d m%0d d%0d wd%0d %0d:%0d:%0d", c.cur_year, c.cur_month,
                     c.cur_date, c.cur_weekday, c.cur_hour, c.cur_minute,
                     c.cur_second);
  endfunction

  // Offer one word, hold it until accepted, then queue its prediction.
  // Gaps are skipped in every third stretch of 150 words.
  task automatic send_word(in_word_t w, bit typed, out_word_t want);
    int        gap;
    int        roll;
    out_word_t pred;
    gap = 0;
    if ((words_sent / 150) % 3 != 0) begin
      roll = $urandom_range(0, 99);
      if (roll < 25) gap = $urandom_range(1, 3);
      else if (roll < 28) gap = $urandom_range(8, 30);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    pred = advance_calendar(w);
    due_cal_q.push_back(typed ? want : pred);
    words_sent++;
  endtask

  // Compare one accepted result against the oldest prediction
  task automatic check_result(out_word_t got);
    out_word_t want;
    string     diff;
    results_seen++;
    if (due_cal_q.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("unexpected result at cycle %0d: %s", cycle_count, fmt_cal(got));
      return;
    end
    want = due_cal_q.pop_front();
    diff = "";
    if (got.cur_year    !== want.cur_year)    diff = {diff, " year"};
    if (got.cur_month   !== want.cur_month)   diff = {diff, " month"};
    if (got.cur_date    !== want.cur_date)    diff = {diff, " date"};
    if (got.cur_weekday !== want.cur_weekday) diff = {diff, " weekday"};
    if (got.cur_hour    !== want.cur_hour)    diff = {diff, " hour"};
    if (got.cur_minute  !== want.cur_minute)  diff = {diff, " minute"};
    if (got.cur_second  !== want.cur_second)  diff = {diff, " second"};
    if (diff != "") begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("result %0d wrong in%s: expected %s, got %s", results_seen, diff,
                 fmt_cal(want), fmt_cal(got));
    end
  endtask

  // Result side: check accepted words and stall at random. No new random
  // stalls start in every third block of the cycle count. Once 300 results
  // are in, hold off for a long stretch so the block backs up into its input.
  initial begin : result_side
    int hold_left;
    int roll;
    bit long_hold_done;
    hold_left      = 0;
    long_hold_done = 1'b0;
    out_stall_i    = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) check_result(out_word_o);
      if (!long_hold_done && results_seen >= 300) begin
        hold_left      = 400;
        long_hold_done = 1'b1;
      end else if (hold_left == 0 && (cycle_count / 256) % 3 != 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 20) hold_left = $urandom_range(1, 3);
        else if (roll < 22) hold_left = $urandom_range(10, 40);
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Word side: directed table first, then random day-end scenarios
  initial begin : word_side
    in_word_t    w;
    logic [7:0]  yr;
    int unsigned mo;
    int unsigned dl;
    int unsigned dt;
    int          kind;
    int          n_ticks;
    int          rand_words;
    bit          drained_once;
    out_word_t   none;

    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_word_i    = '0;
    rand_words   = 0;
    drained_once = 1'b0;
    none         = '0;

    w        = '0;
    w.action = ACT_TICK;
    // first tick out of reset
    add_row(w, 1'b1, cal_out(0, 1, 1, 1, 0, 0, 1));
    // last second of the last year, then wrap everything
    add_row(load_word(255, 12, 31, 7, 23, 59, 59), 1'b1,
            cal_out(255, 12, 31, 7, 23, 59, 59));
    add_row(w, 1'b1, cal_out(0, 1, 1, 1, 0, 0, 0));
    // all-zero load, including the zero month, date and weekday
    add_row(load_word(0, 0, 0, 0, 0, 0, 0), 1'b1, cal_out(0, 0, 0, 0, 0, 0, 0));
    add_row(w, 1'b1, cal_out(0, 0, 0, 0, 0, 0, 1));
    // leap February into its 29th, then into March
    add_row(load_word(4, 2, 28, 3, 23, 59, 59), 1'b0, none);
    add_row(w, 1'b0, none);
    add_row(load_word(4, 2, 29, 4, 23, 59, 59), 1'b0, none);
    add_row(w, 1'b0, none);
    // common February ends on the 28th
    add_row(load_word(5, 2, 28, 6, 23, 59, 59), 1'b0, none);
    add_row(w, 1'b0, none);
    // 30-day month end with weekday wrap
    add_row(load_word(9, 4, 30, 7, 23, 59, 59), 1'b0, none);
    add_row(w, 1'b0, none);
    // month code zero wraps to January without a new year
    add_row(load_word(7, 0, 31, 0, 23, 59, 59), 1'b0, none);
    add_row(w, 1'b0, none);
    // month code above twelve wraps with a new year
    add_row(load_word(3, 13, 31, 5, 23, 59, 59), 1'b0, none);
    add_row(w, 1'b0, none);
    // every load bit set: time past the day end, hour masked
    add_row(load_word(255, 15, 31, 7, 31, 63, 63), 1'b0, none);
    add_row(w, 1'b0, none);
    // exactly one day of seconds, date beyond February's length
    add_row(load_word(1, 2, 30, 2, 24, 0, 0), 1'b0, none);
    add_row(w, 1'b0, none);
    // out-of-range minute and second carry over the day end
    add_row(load_word(2, 6, 0, 0, 23, 60, 60), 1'b0, none);
    add_row(w, 1'b0, none);
    add_row(w, 1'b0, none);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) send_word(plan[i].word, plan[i].typed, plan[i].want);

    while (rand_words < RAND_WORDS) begin
      // Once, pause the input until every result is back
      if (!drained_once && rand_words >= 600) begin
        drained_once = 1'b1;
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (due_cal_q.size() != 0) @(posedge clk_i);
      end
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        // Well-formed load near the end of a day, mostly at month end
        yr = 8'($urandom_range(0, 255));
        mo = $urandom_range(1, 12);
        dl = days_in(mo, yr);
        dt = ($urandom_range(0, 2) != 0) ? dl - $urandom_range(0, 1)
                                         : $urandom_range(1, dl);
        send_word(load_word(yr, mo, dt, $urandom_range(1, 7), 23, 59,
                            $urandom_range(30, 59)), 1'b0, none);
        n_ticks = $urandom_range(1, 40);
      end else if (kind < 18) begin
        // Load with arbitrary bits in every field
        send_word(random_word(ACT_LOAD), 1'b0, none);
        n_ticks = $urandom_range(1, 10);
      end else begin
        n_ticks = $urandom_range(50, 150);
      end
      rand_words++;
      // Ticks carry junk in the load fields
      for (int k = 0; k < n_ticks && rand_words < RAND_WORDS; k++) begin
        send_word(random_word(ACT_TICK), 1'b0, none);
        rand_words++;
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (due_cal_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run: %0d words sent (%0d loads), %0d results checked, %0d mismatches",
             words_sent, loads_seen, results_seen, mismatches);
    $display("run: calendar crossed %0d day, %0d month and %0d year boundaries",
             day_rolls, month_rolls, year_rolls);
    if (mismatches == 0 && due_cal_q.size() == 0) begin
      $display("PASS rtc_calendar_counter");
    end else begin
      $display("FAIL rtc_calendar_counter");
    end
    $finish;
  end

endmodule

[filelist.f]
src/rtc_cal_pkg.sv
src/rtc_cal_in_stage.sv
src/rtc_cal_core.sv
src/rtc_calendar_counter.sv
src/rtc_cal_checker.sv
verif/tb.sv
